>>> src/euclidean_distance_engine_assert.svh
`ifndef EUCLIDEAN_DISTANCE_ENGINE_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_ENGINE_ASSERT_SVH

// clocked assertion, disabled while reset is held
`define EDD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, live during reset as well
`define EDD_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/edd_pkg.sv
package edd_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int MAX_DIMENSIONS      = 1024;
    localparam int SUM_W               = 48;
    localparam int CFG_ADDR_W          = 2;
    localparam int CFG_DATA_W          = 11;
    localparam int CNT_W               = CFG_DATA_W + 1;
    localparam int QUEUE_DEPTH         = 4;
    localparam int ROOT_STEPS          = SUM_W / 2;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [CFG_ADDR_W-1:0] REG_DIMENSION_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TAKE_ROOT       = 2'd1;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] dimension_count;
        logic                  take_root;
    } edd_cfg_t;

endpackage

>>> src/edd_queue.sv
module edd_queue
    import edd_pkg::*;
#(
    parameter int WIDTH = 18,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_Q-1:0] FULL_CNT = CNT_Q'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_Q-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/edd_front.sv
module edd_front
    import edd_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
    parameter int S_TDATA_W       = ((2 * COMPONENT_WIDTH + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  edd_cfg_t                 cfg,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_W-1:0]     s_tdata,
    input  logic                     q_full,
    output logic                     q_push,
    output logic [COMPONENT_WIDTH+1:0] q_data
);

    localparam int CW = COMPONENT_WIDTH;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIMENSIONS);

    logic [CW-1:0]         a_raw;
    logic [CW-1:0]         b_raw;
    logic [CW:0]           diff;
    logic [CW:0]           mag;
    logic [CNT_W-1:0]      dim;
    logic [CNT_W-1:0]      eff_count;
    logic [CNT_W-1:0]      taken;
    logic                  last;
    logic [CFG_DATA_W-1:0] index_reg;

    assign a_raw = s_tdata[CW-1:0];
    assign b_raw = s_tdata[2*CW-1:CW];
    assign diff  = {a_raw[CW-1], a_raw} - {b_raw[CW-1], b_raw};
    assign mag   = diff[CW] ? (~diff + 1'b1) : diff;

    assign dim   = {1'b0, cfg.dimension_count};
    always_comb begin
        if (dim == '0) begin
            eff_count = CNT_W'(1);
        end else if (dim > MAX_CNT) begin
            eff_count = MAX_CNT;
        end else begin
            eff_count = dim;
        end
    end

    assign taken    = {1'b0, index_reg} + 1'b1;
    assign last     = (taken >= eff_count);
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign q_data   = {last, mag};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
        end else if (q_push) begin
            index_reg <= last ? '0 : taken[CFG_DATA_W-1:0];
        end
    end

endmodule

>>> src/edd_back.sv
module edd_back
    import edd_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  edd_cfg_t                   cfg,
    input  logic                       q_not_empty,
    input  logic [COMPONENT_WIDTH+1:0] q_data,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [SUM_W-1:0]           m_tdata,
    output logic                       m_tuser
);

    localparam int MAG_W = COMPONENT_WIDTH + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int ACC_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
    localparam logic [SUM_W-1:0] ROOT_FIRST_BIT = SUM_W'(1) << (2 * ROOT_STEPS - 2);

    logic [MAG_W-1:0] q_mag;
    logic             q_last;

    logic             sq_valid_reg;
    logic             sq_last_reg;
    logic [SQ_W-1:0]  sq_reg;

    logic [SUM_W-1:0] sum_reg;
    logic             sat_reg;

    logic             rooting_reg;
    logic             root_ovf_reg;
    logic [SUM_W-1:0] x_reg;
    logic [SUM_W-1:0] root_reg;
    logic [SUM_W-1:0] bit_reg;

    logic             out_valid_reg;
    logic             out_ovf_reg;
    logic [SUM_W-1:0] out_dist_reg;

    logic             out_free;
    logic             sq_adv;
    logic             root_done;
    logic             root_load;
    logic             finish_direct;
    logic             finish_root;
    logic [ACC_W-1:0] acc;
    logic             sat_now;
    logic [SUM_W-1:0] sum_next;
    logic             ovf_next;
    logic [SUM_W-1:0] trial;
    logic             fits;

    assign q_mag  = q_data[MAG_W-1:0];
    assign q_last = q_data[MAG_W];

    assign out_free      = !out_valid_reg || m_tready;
    assign sq_adv        = sq_valid_reg && (!sq_last_reg || (!rooting_reg && out_free));
    assign q_pop         = q_not_empty && (!sq_valid_reg || sq_adv);
    assign root_done     = rooting_reg && (bit_reg == '0);
    assign root_load     = root_done && out_free;
    assign finish_direct = sq_adv && sq_last_reg && !cfg.take_root;
    assign finish_root   = sq_adv && sq_last_reg && cfg.take_root;

    assign acc      = ACC_W'(sum_reg) + ACC_W'(sq_reg);
    assign sat_now  = (acc > ACC_W'(SUM_MAX));
    assign sum_next = sat_now ? SUM_MAX : acc[SUM_W-1:0];
    assign ovf_next = sat_reg || sat_now;

    assign trial = root_reg + bit_reg;
    assign fits  = (x_reg >= trial);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_dist_reg;
    assign m_tuser  = out_ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            rooting_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                sq_valid_reg <= 1'b1;
            end else if (sq_adv) begin
                sq_valid_reg <= 1'b0;
            end

            if (sq_adv) begin
                if (sq_last_reg) begin
                    sum_reg <= '0;
                    sat_reg <= 1'b0;
                end else begin
                    sum_reg <= sum_next;
                    sat_reg <= ovf_next;
                end
            end

            if (finish_root) begin
                rooting_reg <= 1'b1;
            end else if (root_load) begin
                rooting_reg <= 1'b0;
            end

            if (finish_direct || root_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            sq_reg      <= q_mag * q_mag;
            sq_last_reg <= q_last;
        end

        if (finish_root) begin
            x_reg        <= sum_next;
            root_reg     <= '0;
            bit_reg      <= ROOT_FIRST_BIT;
            root_ovf_reg <= ovf_next;
        end else if (rooting_reg && !root_done) begin
            if (fits) begin
                x_reg    <= x_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        if (finish_direct) begin
            out_dist_reg <= sum_next;
            out_ovf_reg  <= ovf_next;
        end else if (root_load) begin
            out_dist_reg <= root_reg;
            out_ovf_reg  <= root_ovf_reg;
        end
    end

endmodule

>>> src/euclidean_distance_engine.sv
// Path: a word is registered in the queue, then squared into sq_reg; a vector's last word
// yields the registered squared distance, or its root via 24 two-bit root-unit steps.
// Throughput: one word per cycle while the queue has room; a final word waits while the
// previous root is still in the root unit or the previous result is not yet taken.
// Reset: synchronous, active low; clears queue, sum, count and result; dimension_count
// and take_root return to 1.
module euclidean_distance_engine
    import edd_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
    parameter int S_TDATA_W       = ((2 * COMPONENT_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // component_a, component_b, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SUM_W-1:0]      m_tdata,   // distance
    output logic                  m_tuser    // overflowed
);

    localparam int Q_W = COMPONENT_WIDTH + 2;

    logic [CFG_DATA_W-1:0] dim_count_reg;
    logic                  take_root_reg;
    edd_cfg_t              cfg;

    logic           q_full;
    logic           q_push;
    logic [Q_W-1:0] q_push_data;
    logic           q_pop;
    logic           q_not_empty;
    logic [Q_W-1:0] q_pop_data;

    assign cfg.dimension_count = dim_count_reg;
    assign cfg.take_root       = take_root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_count_reg <= CFG_DATA_W'(1);
            take_root_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DIMENSION_COUNT: dim_count_reg <= cfg_wdata;
                REG_TAKE_ROOT:       take_root_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    edd_front #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH),
        .S_TDATA_W       (S_TDATA_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    edd_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    edd_back #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

>>> src/edd_checker.sv
`include "euclidean_distance_engine_assert.svh"

module edd_checker
    import edd_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [SUM_W-1:0] m_tdata,
    input logic             m_tuser
);

    localparam logic [SUM_W-1:0] ROOT_OF_MAX = SUM_W'({(SUM_W / 2){1'b1}});

    `EDD_ASSERT(a_valid_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")
    `EDD_ASSERT(a_word_holds, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
    `EDD_ASSERT(a_sat_value, aclk, aresetn, m_tvalid && m_tuser |-> (m_tdata == SUM_MAX) || (m_tdata == ROOT_OF_MAX), "overflowed result not at saturation value")
    `EDD_ASSERT_NR(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind euclidean_distance_engine edd_checker u_edd_checker (.*);

>>> dv/euclidean_distance_engine_tb.sv
module euclidean_distance_engine_tb;
    import edd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int TDATA_W        = 32;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int RANDOM_PAIRS   = 760;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0] distance;
        logic             overflowed;
    } distance_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SUM_W-1:0]      m_tdata;
    logic                  m_tuser;

    logic [TDATA_W-1:0]    pending_pairs[$];
    distance_result_t      expected_distances[$];

    logic [SUM_W-1:0]      acc_sum       = '0;
    logic [CFG_DATA_W-1:0] acc_count     = '0;
    logic                  acc_saturated = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_dims      = 11'd1;
    logic                  cfg_root      = 1'b1;

    logic                  no_idle   = 1'b0;
    int                    in_gap    = 0;
    int                    out_stall = 0;
    int                    out_draw;
    int                    error_count = 0;

    euclidean_distance_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // component_a, component_b, zero pad
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // distance
        .m_tuser   (m_tuser)    // overflowed
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    function automatic logic [SUM_W-1:0] floor_root(input logic [SUM_W-1:0] x);
        logic [SUM_W+1:0] rem;
        logic [SUM_W+1:0] trial;
        logic [SUM_W/2-1:0] q;
        int i;
        rem = '0;
        q   = '0;
        for (i = SUM_W / 2 - 1; i >= 0; i--) begin
            rem   = {rem[SUM_W-1:0], x[2*i+1 -: 2]};
            trial = {{(SUM_W/2){1'b0}}, q, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                q   = {q[SUM_W/2-2:0], 1'b1};
            end else begin
                q   = {q[SUM_W/2-2:0], 1'b0};
            end
        end
        return {{(SUM_W/2){1'b0}}, q};
    endfunction

    task automatic take_pair(input logic [15:0] a, input logic [15:0] b);
        logic signed [16:0] diff;
        logic [16:0]        mag;
        logic [33:0]        square;
        logic [SUM_W:0]     total;
        logic [11:0]        taken;
        logic [11:0]        limit;
        distance_result_t   res;
        diff   = $signed({a[15], a}) - $signed({b[15], b});
        mag    = diff[16] ? -diff : diff;
        square = mag * mag;
        total  = {1'b0, acc_sum} + square;
        if (total > {1'b0, SUM_MAX}) begin
            acc_sum       = SUM_MAX;
            acc_saturated = 1'b1;
        end else begin
            acc_sum = total[SUM_W-1:0];
        end
        taken = {1'b0, acc_count} + 12'd1;
        if (cfg_dims == 0)
            limit = 12'd1;
        else if (cfg_dims > MAX_DIMENSIONS)
            limit = 12'(MAX_DIMENSIONS);
        else
            limit = {1'b0, cfg_dims};
        if (taken >= limit) begin
            res.distance   = cfg_root ? floor_root(acc_sum) : acc_sum;
            res.overflowed = acc_saturated;
            expected_distances.push_back(res);
            acc_sum       = '0;
            acc_count     = '0;
            acc_saturated = 1'b0;
        end else begin
            acc_count = taken[CFG_DATA_W-1:0];
        end
    endtask

    function automatic logic [15:0] draw_component();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        if (idx == REG_DIMENSION_COUNT)
            cfg_dims = value;
        else if (idx == REG_TAKE_ROOT)
            cfg_root = value[0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (pending_pairs.size() != 0 || s_tvalid || expected_distances.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_vectors(input logic [CFG_DATA_W-1:0] dims, input logic root,
                               input int count);
        int i;
        write_register(REG_DIMENSION_COUNT, dims);
        write_register(REG_TAKE_ROOT, {10'd0, root});
        no_idle <= ($urandom_range(0, 3) == 0);
        for (i = 0; i < count; i++)
            pending_pairs.push_back({draw_component(), draw_component()});
        settle();
    endtask

    // feed words, hold on backpressure, idle for a random gap between words unless no_idle is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            in_gap   <= 0;
        end else if (s_tvalid && !s_tready) begin
        end else if (in_gap != 0) begin
            s_tvalid <= 1'b0;
            in_gap   <= in_gap - 1;
        end else if (pending_pairs.size() != 0) begin
            s_tdata  <= pending_pairs.pop_front();
            s_tvalid <= 1'b1;
            in_gap   <= no_idle ? 0 : $urandom_range(0, 9);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            take_pair(s_tdata[15:0], s_tdata[31:16]);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            out_stall <= 0;
        end else if (m_tvalid && m_tready) begin
            if (expected_distances.size() == 0) begin
                $display("%0t: result with none expected: expected none, actual %h/%b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                distance_result_t want;
                want = expected_distances.pop_front();
                if (m_tdata !== want.distance) begin
                    $display("%0t: distance mismatch: expected %h, actual %h",
                             $time, want.distance, m_tdata);
                    error_count++;
                end
                if (m_tuser !== want.overflowed) begin
                    $display("%0t: overflowed mismatch: expected %b, actual %b",
                             $time, want.overflowed, m_tuser);
                    error_count++;
                end
            end
            out_draw  = no_idle ? 0 : $urandom_range(0, 9);
            out_stall <= out_draw;
            m_tready  <= (out_draw == 0);
        end else if (out_stall != 0) begin
            out_stall <= out_stall - 1;
            m_tready  <= (out_stall == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("euclidean_distance_engine_tb failed");
        $finish;
    end

    initial begin
        int total;
        int eff;
        int count;
        logic [CFG_DATA_W-1:0] dims;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: one pair per vector, root taken
        pending_pairs.push_back({16'h8000, 16'h7fff});
        pending_pairs.push_back({16'h7fff, 16'h8000});
        pending_pairs.push_back({16'h0000, 16'h0000});
        pending_pairs.push_back({16'h8000, 16'h8000});
        pending_pairs.push_back({16'h0000, 16'h0001});
        pending_pairs.push_back({16'h0001, 16'hffff});
        settle();

        // zero count acts as one; spare indexes drop the write
        write_register(REG_DIMENSION_COUNT, 11'd0);
        write_register(REG_TAKE_ROOT, 11'd0);
        write_register(REG_SPARE_2, 11'd5);
        write_register(REG_SPARE_3, 11'h7ff);
        pending_pairs.push_back({16'h8000, 16'h7fff});
        pending_pairs.push_back({16'h0001, 16'hffff});
        pending_pairs.push_back({16'hedcc, 16'h1234});
        settle();

        // lower the count and change the mode mid-vector
        write_register(REG_DIMENSION_COUNT, 11'd4);
        write_register(REG_TAKE_ROOT, 11'd1);
        pending_pairs.push_back({16'h8000, 16'h7fff});
        pending_pairs.push_back({16'hedcc, 16'h1234});
        settle();
        write_register(REG_DIMENSION_COUNT, 11'd2);
        write_register(REG_TAKE_ROOT, 11'd0);
        pending_pairs.push_back({16'h0000, 16'h0100});
        settle();

        // count above the ceiling, longest vector
        run_vectors(11'h7ff, 1'b1, MAX_DIMENSIONS);

        total = 0;
        while (total < RANDOM_PAIRS) begin
            case ($urandom_range(0, 19))
                0:       dims = 11'd0;
                1, 2:    dims = 11'($urandom_range(9, 64));
                default: dims = 11'($urandom_range(1, 8));
            endcase
            eff   = (dims == 0) ? 1 : dims;
            count = eff * $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0)
                count += $urandom_range(1, eff);
            run_vectors(dims, 1'($urandom_range(0, 1)), count);
            total += count;
        end

        if (error_count == 0)
            $display("euclidean_distance_engine_tb passed");
        else
            $display("euclidean_distance_engine_tb failed");
        $finish;
    end

endmodule
